/* design/tmge_pkg.sv */
// Shared types and constants for the text mode glyph expander.
package tmge_pkg;

  localparam int FONT_DEPTH  = 4096;
  localparam int FONT_AW     = 12;
  localparam int CODE_SPACE  = 256;
  localparam int ROW_LIMIT   = 16;
  localparam int CFG_DW      = 13;
  localparam int CFG_IW      = 3;

  // Input commands
  localparam logic CMD_FONT_WRITE = 1'b0;
  localparam logic CMD_DRAW       = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_CHAR_WIDTH   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_CHAR_HEIGHT  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_DOUBLE_WIDTH = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_BLINK_ENABLE = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_BLINK_PHASE  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_LINE_STRIDE  = 3'd5;

  // Configuration reset values
  localparam logic [3:0]  RST_CHAR_WIDTH   = 4'd8;
  localparam logic [4:0]  RST_CHAR_HEIGHT  = 5'd14;
  localparam logic        RST_DOUBLE_WIDTH = 1'b0;
  localparam logic        RST_BLINK_ENABLE = 1'b1;
  localparam logic        RST_BLINK_PHASE  = 1'b0;
  localparam logic [12:0] RST_LINE_STRIDE  = 13'd640;

  localparam logic [3:0] GLYPH_MAX_WIDTH = 4'd8;
  localparam int         ATTR_BLINK_BIT  = 7;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_BASE = 4'b0100,
    ST_ROWS = 4'b1000
  } seq_state_t;

  // Per-row side information that travels with a font read
  typedef struct packed {
    logic [23:0] row_address;
    logic [3:0]  fg;
    logic [3:0]  bg;
    logic [3:0]  width;
    logic        dbl;
    logic        last;
  } row_meta_t;

endpackage

/* design/tmge_ram.sv */
// Generic simple dual port RAM with registered read data.
module tmge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/tmge_seq.sv */
// Input acceptance, configuration registers and per-row font read sequencer.
module tmge_seq #(
  parameter int MAX_GLYPH_ROWS = 16,
  parameter int GLYPH_COUNT    = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [7:0]                 in_cell_x,
  input  logic [7:0]                 in_cell_y,
  input  logic [7:0]                 in_char_code,
  input  logic [7:0]                 in_attribute,
  input  logic [11:0]                in_font_addr,
  input  logic [7:0]                 in_font_data,
  input  logic                       cfg_we,
  input  logic [tmge_pkg::CFG_IW-1:0] cfg_index,
  input  logic [tmge_pkg::CFG_DW-1:0] cfg_data,
  output logic                       ram_we,
  output logic [tmge_pkg::FONT_AW-1:0] ram_waddr,
  output logic [7:0]                 ram_wdata,
  output logic [tmge_pkg::FONT_AW-1:0] ram_raddr,
  input  logic                       room,
  output logic                       issue,
  output tmge_pkg::row_meta_t        meta
);
  import tmge_pkg::*;

  localparam int HMAX = (MAX_GLYPH_ROWS < ROW_LIMIT) ? MAX_GLYPH_ROWS : ROW_LIMIT;

  seq_state_t state_r, state_nxt;

  logic [3:0]  cw_r;
  logic [4:0]  ch_r;
  logic        dbl_cfg_r;
  logic        blink_en_r;
  logic        blink_ph_r;
  logic [12:0] stride_r;

  logic [7:0]  cx_r, cy_r, code_r;
  logic [3:0]  fg_r, bg_r, w_r;
  logic [4:0]  h_r;
  logic        dbl_r;
  logic [11:0] codeh_r, cyh_r;
  logic [12:0] xoff_r;
  logic [23:0] addr_r;
  logic [11:0] faddr_r;
  logic [3:0]  row_r;

  logic [7:0]  code_mod_tbl [CODE_SPACE];
  logic        accept, draw, last;
  logic [3:0]  w_clamp, bg_in, fg_in;
  logic [4:0]  h_clamp;
  logic        blink;
  logic [11:0] cxw;
  logic [24:0] base_sum;

  // Residue table of the character code
  for (genvar gi = 0; gi < CODE_SPACE; gi++) begin : g_mod
    assign code_mod_tbl[gi] = 8'(gi % GLYPH_COUNT);
  end

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign draw     = accept && (in_cmd == CMD_DRAW);

  assign ram_we    = accept && (in_cmd == CMD_FONT_WRITE);
  assign ram_waddr = in_font_addr;
  assign ram_wdata = in_font_data;
  assign ram_raddr = faddr_r;

  assign w_clamp = (cw_r == 4'd0) ? 4'd1 :
                   (cw_r > GLYPH_MAX_WIDTH) ? GLYPH_MAX_WIDTH : cw_r;
  assign h_clamp = (ch_r == 5'd0) ? 5'd1 :
                   (ch_r > 5'(HMAX)) ? 5'(HMAX) : ch_r;

  assign blink = blink_en_r && in_attribute[ATTR_BLINK_BIT];
  assign bg_in = {in_attribute[ATTR_BLINK_BIT] && !blink_en_r, in_attribute[6:4]};
  assign fg_in = (blink && blink_ph_r) ? bg_in : in_attribute[3:0];

  assign cxw      = 12'(cx_r * w_r);
  assign base_sum = 25'(cyh_r) * 25'(stride_r) + 25'(xoff_r);

  assign last  = ({1'b0, row_r} == (h_r - 5'd1));
  assign issue = (state_r == ST_ROWS) && room;

  assign meta.row_address = addr_r;
  assign meta.fg          = fg_r;
  assign meta.bg          = bg_r;
  assign meta.width       = w_r;
  assign meta.dbl         = dbl_r;
  assign meta.last        = last;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (draw) state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_BASE;
      ST_BASE: state_nxt = ST_ROWS;
      ST_ROWS: if (issue && last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cw_r       <= RST_CHAR_WIDTH;
      ch_r       <= RST_CHAR_HEIGHT;
      dbl_cfg_r  <= RST_DOUBLE_WIDTH;
      blink_en_r <= RST_BLINK_ENABLE;
      blink_ph_r <= RST_BLINK_PHASE;
      stride_r   <= RST_LINE_STRIDE;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHAR_WIDTH:   cw_r       <= cfg_data[3:0];
          CFG_CHAR_HEIGHT:  ch_r       <= cfg_data[4:0];
          CFG_DOUBLE_WIDTH: dbl_cfg_r  <= cfg_data[0];
          CFG_BLINK_ENABLE: blink_en_r <= cfg_data[0];
          CFG_BLINK_PHASE:  blink_ph_r <= cfg_data[0];
          CFG_LINE_STRIDE:  stride_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Cell payload and row walk
  always_ff @(posedge clk) begin
    if (draw) begin
      cx_r   <= in_cell_x;
      cy_r   <= in_cell_y;
      code_r <= code_mod_tbl[in_char_code];
      fg_r   <= fg_in;
      bg_r   <= bg_in;
      w_r    <= w_clamp;
      h_r    <= h_clamp;
      dbl_r  <= dbl_cfg_r;
    end
    if (state_r == ST_CALC) begin
      codeh_r <= 12'(code_r * h_r);
      cyh_r   <= 12'(cy_r * h_r);
      xoff_r  <= dbl_r ? {cxw, 1'b0} : {1'b0, cxw};
    end
    if (state_r == ST_BASE) begin
      addr_r  <= base_sum[23:0];
      faddr_r <= codeh_r;
      row_r   <= 4'd0;
    end
    if (issue) begin
      addr_r  <= addr_r + {11'd0, stride_r};
      faddr_r <= faddr_r + 12'd1;
      row_r   <= row_r + 4'd1;
    end
  end

`ifndef SYNTHESIS
  a_last_ends_cell: assert property (@(posedge clk) disable iff (!rst_n)
    issue && last |=> state_r == ST_IDLE)
    else $error("sequencer did not return to idle after the last row");
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROWS |-> ({1'b0, row_r} < h_r))
    else $error("row counter ran past the glyph height");
  a_draw_starts: assert property (@(posedge clk) disable iff (!rst_n)
    draw |=> state_r == ST_CALC && !ram_we)
    else $error("draw beat did not start the row walk");
`endif

endmodule

/* design/tmge_out.sv */
// Glyph row expansion and two entry result queue with read credits.
module tmge_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                issue,
  input  tmge_pkg::row_meta_t meta_in,
  input  logic [7:0]          ram_rdata,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [23:0]         out_row_address,
  output logic [63:0]         out_pixel_row,
  output logic [4:0]          out_pixel_count,
  output logic                out_last_row
);
  import tmge_pkg::*;

  typedef struct packed {
    logic [23:0] row_address;
    logic [63:0] pixel_row;
    logic [4:0]  pixel_count;
    logic        last_row;
  } out_beat_t;

  logic      p1_valid_r;
  row_meta_t p1_meta_r;
  out_beat_t q0_r, q1_r, beat_new;
  logic [1:0] qcnt_r, occ_r;
  logic       pop;
  logic [63:0] pix;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (qcnt_r != 2'd0);
  // Count reads in flight plus queued rows; a pop frees a slot at once
  assign room      = (occ_r != 2'd2) || pop;

  always_comb begin
    logic [2:0] px;
    logic       en;
    pix = '0;
    px  = 3'd0;
    en  = 1'b0;
    for (int n = 0; n < 16; n++) begin
      if (p1_meta_r.dbl) begin
        px = 3'(n >> 1);
        en = (4'(n >> 1) < p1_meta_r.width);
      end else begin
        px = 3'(n);
        en = (n < 8) && (4'(n) < p1_meta_r.width);
      end
      if (en) begin
        pix[4*n +: 4] = ram_rdata[3'd7 - px] ? p1_meta_r.fg : p1_meta_r.bg;
      end
    end
  end

  assign beat_new.row_address = p1_meta_r.row_address;
  assign beat_new.pixel_row   = pix;
  assign beat_new.pixel_count = p1_meta_r.dbl ? {p1_meta_r.width, 1'b0}
                                              : {1'b0, p1_meta_r.width};
  assign beat_new.last_row    = p1_meta_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      qcnt_r     <= 2'd0;
      occ_r      <= 2'd0;
    end else begin
      p1_valid_r <= issue;
      occ_r      <= occ_r + {1'b0, issue} - {1'b0, pop};
      qcnt_r     <= qcnt_r + {1'b0, p1_valid_r} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_meta_r <= meta_in;
    end
    // Load the new row at the head when the queue is empty after this cycle's pop,
    // otherwise advance the second entry on a pop.
    if (p1_valid_r && (qcnt_r == 2'd0 || (qcnt_r == 2'd1 && pop))) begin
      q0_r <= beat_new;
    end else if (pop) begin
      q0_r <= q1_r;
    end
    if (p1_valid_r && !(qcnt_r == 2'd0 || (qcnt_r == 2'd1 && pop))) begin
      q1_r <= beat_new;
    end
  end

  assign out_row_address = q0_r.row_address;
  assign out_pixel_row   = q0_r.pixel_row;
  assign out_pixel_count = q0_r.pixel_count;
  assign out_last_row    = q0_r.last_row;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r != 2'd3 && qcnt_r <= occ_r)
    else $error("row credit count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r |-> !(qcnt_r == 2'd2 && !pop))
    else $error("font read returned into a full result queue");
  a_issue_credit: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> room)
    else $error("font read issued without a free result slot");
`endif

endmodule

/* design/text_mode_glyph_expander.sv */
// Draw beat: after ST_CALC and ST_BASE, one row per cycle while out_stall is low.
// A draw stalls the input until its last row read is issued; font writes do not.
// The row rate is set by the single read port of the font RAM, one byte per row.
// A queued result may wait under out_stall while reads continue into free slots.
// Synchronous reset clears control state and reloads the configuration defaults.
// The font RAM is not cleared by reset and is undefined until written.
module text_mode_glyph_expander #(
  parameter int MAX_GLYPH_ROWS = 16,
  parameter int GLYPH_COUNT    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_cell_x,
  input  logic [7:0]  in_cell_y,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_attribute,
  input  logic [11:0] in_font_addr,
  input  logic [7:0]  in_font_data,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // result beat
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_row_address,
  output logic [63:0] out_pixel_row,
  output logic [4:0]  out_pixel_count,
  output logic        out_last_row
);
  import tmge_pkg::*;

  logic               ram_we;
  logic [FONT_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;
  logic               room;
  logic               issue;
  row_meta_t          meta;

  // Sequencer: takes input beats, writes font bytes, and walks the glyph
  // rows of a draw. It first works out the cell setup (glyph base
  // products, then the first frame buffer address), then issues one font
  // read per row while the output side grants a slot.
  tmge_seq #(
    .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS),
    .GLYPH_COUNT    (GLYPH_COUNT)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_cell_x    (in_cell_x),
    .in_cell_y    (in_cell_y),
    .in_char_code (in_char_code),
    .in_attribute (in_attribute),
    .in_font_addr (in_font_addr),
    .in_font_data (in_font_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .room         (room),
    .issue        (issue),
    .meta         (meta)
  );

  // Font store: written only while the sequencer is idle, so a read never
  // overlaps a write to the same byte and no forwarding is needed.
  tmge_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output side: expand the returned font byte to colour nibbles, then
  // hold up to two rows so reads keep flowing past a stalled result.
  tmge_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .issue           (issue),
    .meta_in         (meta),
    .ram_rdata       (ram_rdata),
    .room            (room),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_address (out_row_address),
    .out_pixel_row   (out_pixel_row),
    .out_pixel_count (out_pixel_count),
    .out_last_row    (out_last_row)
  );

endmodule

/* tb/tb_text_mode_glyph_expander.sv */
// Self-checking testbench for the text mode glyph expander: font loads, cell draws, register sweeps.
`timescale 1ns / 1ps

module tb_text_mode_glyph_expander;
  import tmge_pkg::*;

  // Keep the block at its default build; the row model clamps against the same bounds.
  localparam int GLYPH_ROWS_MAX = 16;
  localparam int GLYPH_CODES    = 256;

  // Register indexes past the six defined ones; writes there must change nothing.
  localparam logic [CFG_IW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_SPARE_B = 3'd7;

  // Margin after the last expected row has been checked, before touching the
  // registers or ending the run.
  localparam int SETTLE_CYCLES = 10;
  localparam int QUIET_LIMIT   = 1000;
  localparam int PHASE_ITEMS   = 60;
  localparam int PHASE_COUNT   = 8;

  typedef struct packed {
    logic [23:0] row_address;
    logic [63:0] pixel_row;
    logic [4:0]  pixel_count;
    logic        last_row;
  } glyph_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = CMD_FONT_WRITE;
  logic [7:0]  in_cell_x = '0;
  logic [7:0]  in_cell_y = '0;
  logic [7:0]  in_char_code = '0;
  logic [7:0]  in_attribute = '0;
  logic [11:0] in_font_addr = '0;
  logic [7:0]  in_font_data = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] out_row_address;
  logic [63:0] out_pixel_row;
  logic [4:0]  out_pixel_count;
  logic        out_last_row;

  // Shadow of the block: its font RAM, which entries hold real data, and its registers.
  logic [7:0]  font_shadow [FONT_DEPTH];
  bit          font_written [FONT_DEPTH];
  logic [3:0]  cfg_char_width   = RST_CHAR_WIDTH;
  logic [4:0]  cfg_char_height  = RST_CHAR_HEIGHT;
  logic        cfg_double_width = RST_DOUBLE_WIDTH;
  logic        cfg_blink_enable = RST_BLINK_ENABLE;
  logic        cfg_blink_phase  = RST_BLINK_PHASE;
  logic [12:0] cfg_line_stride  = RST_LINE_STRIDE;

  glyph_row_t  pending_rows [$];
  bit          quiet = 1'b0;
  int          errors = 0;
  int          rows_checked = 0;
  int          draws_sent = 0;
  int          font_writes_sent = 0;
  int          settings_used = 1;

  text_mode_glyph_expander #(
    .MAX_GLYPH_ROWS(GLYPH_ROWS_MAX),
    .GLYPH_COUNT   (GLYPH_CODES)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_char_code   (in_char_code),
    .in_attribute   (in_attribute),
    .in_font_addr   (in_font_addr),
    .in_font_data   (in_font_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_address(out_row_address),
    .out_pixel_row  (out_pixel_row),
    .out_pixel_count(out_pixel_count),
    .out_last_row   (out_last_row)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Glyph row prediction
  // ---------------------------------------------------------------------------

  // Width actually used: 0 acts as one pixel, anything past 8 as 8.
  function automatic int unsigned glyph_width();
    int unsigned w;
    w = cfg_char_width;
    if (w < 1) w = 1;
    if (w > GLYPH_MAX_WIDTH) w = GLYPH_MAX_WIDTH;
    return w;
  endfunction

  // Height actually used: at least one row, at most the row bound of the build.
  function automatic int unsigned glyph_height();
    int unsigned h, hmax;
    hmax = GLYPH_ROWS_MAX;
    if (hmax > ROW_LIMIT) hmax = ROW_LIMIT;
    if (hmax < 1) hmax = 1;
    h = cfg_char_height;
    if (h < 1) h = 1;
    if (h > hmax) h = hmax;
    return h;
  endfunction

  function automatic logic [11:0] glyph_byte_addr(input logic [7:0] code, input int unsigned row);
    int unsigned idx;
    idx = ((code % GLYPH_CODES) * glyph_height() + row) % FONT_DEPTH;
    return idx[11:0];
  endfunction

  function automatic bit glyph_ready(input logic [7:0] code);
    for (int unsigned row = 0; row < glyph_height(); row++)
      if (!font_written[glyph_byte_addr(code, row)]) return 1'b0;
    return 1'b1;
  endfunction

  // Expand one text cell into its rows and queue them in output order.
  function automatic void expand_cell(input logic [7:0] cx, input logic [7:0] cy,
                                      input logic [7:0] code, input logic [7:0] attr);
    int unsigned w, h, mul;
    logic [31:0] addr_full;
    logic [7:0]  a, bits;
    logic [3:0]  fg, bg, c;
    glyph_row_t  r;
    w = glyph_width();
    h = glyph_height();
    mul = cfg_double_width ? 2 : 1;
    a = attr;
    // Blink strips the top attribute bit; in the off phase the foreground
    // takes the background color so the cell shows blank.
    if (cfg_blink_enable && a[ATTR_BLINK_BIT]) begin
      a[ATTR_BLINK_BIT] = 1'b0;
      if (cfg_blink_phase) a = {a[7:4], a[7:4]};
    end
    bg = a[7:4];
    fg = a[3:0];
    for (int unsigned row = 0; row < h; row++) begin
      bits = font_shadow[glyph_byte_addr(code, row)];
      addr_full = (cy * h + row) * cfg_line_stride + cx * w * mul;
      r.row_address = addr_full[23:0];
      r.pixel_row = '0;
      for (int unsigned px = 0; px < w; px++) begin
        c = bits[7 - px] ? fg : bg;
        if (mul == 2) r.pixel_row[8*px +: 8] = {c, c};
        else r.pixel_row[4*px +: 4] = c;
      end
      r.pixel_count = 5'(w * mul);
      r.last_row = (row + 1 == h);
      pending_rows.push_back(r);
    end
  endfunction

  // Mirror a register write; unknown indexes leave everything alone.
  function automatic void shadow_write(input logic [2:0] idx, input logic [12:0] data);
    case (idx)
      CFG_CHAR_WIDTH:   cfg_char_width   = data[3:0];
      CFG_CHAR_HEIGHT:  cfg_char_height  = data[4:0];
      CFG_DOUBLE_WIDTH: cfg_double_width = data[0];
      CFG_BLINK_ENABLE: cfg_blink_enable = data[0];
      CFG_BLINK_PHASE:  cfg_blink_phase  = data[0];
      CFG_LINE_STRIDE:  cfg_line_stride  = data[12:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Present one input beat and hold it until accepted. Valid stays high on return
  // so that a back-to-back beat follows without a bubble.
  task automatic send_item(input logic cmd, input logic [7:0] cx, input logic [7:0] cy,
                           input logic [7:0] code, input logic [7:0] attr,
                           input logic [11:0] faddr, input logic [7:0] fdata);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_cell_x    <= cx;
    in_cell_y    <= cy;
    in_char_code <= code;
    in_attribute <= attr;
    in_font_addr <= faddr;
    in_font_data <= fdata;
    do @(posedge clk); while (in_stall);
    // Beat taken at this edge: update the shadow or queue the rows.
    if (cmd == CMD_FONT_WRITE) begin
      font_shadow[faddr] = fdata;
      font_written[faddr] = 1'b1;
      font_writes_sent++;
    end else begin
      expand_cell(cx, cy, code, attr);
      draws_sent++;
    end
  endtask

  // Font write; the draw fields carry noise the block must ignore.
  task automatic write_font(input logic [11:0] faddr, input logic [7:0] fdata);
    send_item(CMD_FONT_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              faddr, fdata);
  endtask

  // Cell draw; the font fields carry noise the block must ignore.
  task automatic draw_cell(input logic [7:0] cx, input logic [7:0] cy,
                           input logic [7:0] code, input logic [7:0] attr);
    send_item(CMD_DRAW, cx, cy, code, attr, 12'($urandom), 8'($urandom));
  endtask

  // Drop valid and wait until every queued row has come out and the block is quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers plus both spare indexes. Narrow registers get junk in the
  // unused upper data bits, which the block must drop.
  task automatic apply_config(input logic [3:0] cw, input logic [4:0] ch, input logic dbl,
                              input logic ben, input logic bph, input logic [12:0] stride);
    logic [2:0]  idx [8];
    logic [12:0] val [8];
    idx = '{CFG_SPARE_A, CFG_CHAR_WIDTH, CFG_CHAR_HEIGHT, CFG_DOUBLE_WIDTH,
            CFG_BLINK_ENABLE, CFG_BLINK_PHASE, CFG_LINE_STRIDE, CFG_SPARE_B};
    for (int i = 0; i < 8; i++) val[i] = 13'($urandom);
    val[1][3:0] = cw;
    val[2][4:0] = ch;
    val[3][0]   = dbl;
    val[4][0]   = ben;
    val[5][0]   = bph;
    val[6]      = stride;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      shadow_write(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Make sure every font byte of a glyph holds data; now and then rewrite one anyway.
  task automatic load_glyph(input logic [7:0] code);
    logic [11:0] faddr;
    for (int unsigned row = 0; row < glyph_height(); row++) begin
      faddr = glyph_byte_addr(code, row);
      if (!font_written[faddr] || $urandom_range(0, 7) == 0)
        write_font(faddr, 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: 8x14 glyphs, blink on in the visible phase, 640 pixel stride.
  // The top code at the far corner gives the largest address this setting can make.
  task automatic test_reset_defaults();
    logic [7:0] pattern;
    for (int unsigned row = 0; row < glyph_height(); row++) begin
      case (row % 4)
        0: pattern = 8'h00;
        1: pattern = 8'hFF;
        2: pattern = 8'hAA;
        default: pattern = 8'h55;
      endcase
      write_font(glyph_byte_addr(8'hFF, row), pattern);
    end
    draw_cell(8'hFF, 8'hFF, 8'hFF, 8'hA5);  // blink bit set, visible phase
    draw_cell(8'h00, 8'h00, 8'hFF, 8'h0F);
    wait_idle();
  endtask

  // Width and height of zero clamp to one, doubled pixels, widest stride, blink off phase,
  // then a second cell with blink handling disabled.
  task automatic test_clamps_and_blink();
    apply_config(4'd0, 5'd0, 1'b1, 1'b1, 1'b1, 13'h1FFF);
    write_font(glyph_byte_addr(8'h00, 0), 8'h80);
    draw_cell(8'hFF, 8'hFF, 8'h00, 8'h9C);
    wait_idle();
    apply_config(4'd0, 5'd0, 1'b1, 1'b0, 1'b1, 13'h1FFF);
    draw_cell(8'h7F, 8'h80, 8'h00, 8'hF0);
    wait_idle();
  endtask

  // Phases of random cells, each under its own register setting. Blink enable and
  // phase walk all four combinations twice; the last two phases run with no idling.
  task automatic test_random_cells();
    logic [3:0]  cw;
    logic [4:0]  ch;
    logic [12:0] stride;
    logic [7:0]  code;
    int          start;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin cw = 4'd1;  ch = 5'd1;  stride = 13'd1;    end
        1: begin cw = 4'd15; ch = 5'd31; stride = 13'h1FFF; end
        2: begin cw = 4'd8;  ch = 5'd16; stride = 13'd4096; end
        3: begin cw = 4'($urandom_range(9, 15)); ch = 5'($urandom_range(17, 31));
                 stride = 13'd0; end
        default: begin
          cw = 4'($urandom_range(1, 8));
          ch = 5'($urandom_range(1, 16));
          stride = 13'($urandom_range(1, 4096));
        end
      endcase
      if (p >= PHASE_COUNT - 2) quiet = 1'b1;
      apply_config(cw, ch, 1'(p % 3 == 1), 1'(p >> 1), 1'(p), stride);
      start = draws_sent + font_writes_sent;
      while (draws_sent + font_writes_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) begin
          // stray font write anywhere in the RAM
          write_font(12'($urandom), 8'($urandom));
        end else begin
          // favor glyphs already loaded so draws stay frequent
          code = 8'($urandom);
          if ($urandom_range(0, 1) == 1)
            for (int i = 0; i < 12 && !glyph_ready(code); i++) code = 8'($urandom);
          load_glyph(code);
          draw_cell(8'($urandom), 8'($urandom), code, 8'($urandom));
        end
      end
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, row checker, watchdog
  // ---------------------------------------------------------------------------

  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : row_checker
    glyph_row_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row beat, expected none, got address 0x%0h", $time,
                 out_row_address);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        if (out_row_address !== want.row_address)
          report_mismatch("row_address", want.row_address, out_row_address);
        if (out_pixel_row !== want.pixel_row)
          report_mismatch("pixel_row", want.pixel_row, out_pixel_row);
        if (out_pixel_count !== want.pixel_count)
          report_mismatch("pixel_count", want.pixel_count, out_pixel_count);
        if (out_last_row !== want.last_row)
          report_mismatch("last_row", want.last_row, out_last_row);
        rows_checked++;
      end
    end
  end

  // Count cycles with no beat on either side; a hang ends the run.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d rows outstanding", $time, QUIET_LIMIT,
                 pending_rows.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_clamps_and_blink();
    test_random_cells();
    wait_idle();
    $display("Ran %0d font writes and %0d cell draws across %0d register settings,",
             font_writes_sent, draws_sent, settings_used);
    $display("including clamped sizes, doubled pixels and every blink mode; %0d rows compared.",
             rows_checked);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/tmge_pkg.sv
design/tmge_ram.sv
design/tmge_seq.sv
design/tmge_out.sv
design/text_mode_glyph_expander.sv
tb/tb_text_mode_glyph_expander.sv
